// ===== rtl/core/pfcl_pkg.sv =====
`default_nettype none
package pfcl_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int EVICT   = DEPTH / 4;
   localparam int ENTRY_W = 6;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_EXACT = 2'd1;
   localparam logic [1:0] OP_COVER = 2'd2;

   localparam logic [1:0] ADV_NONE = 2'd0;
   localparam logic [1:0] ADV_SEEK = 2'd1;
   localparam logic [1:0] ADV_CONT = 2'd2;

   localparam logic CSR_FRAME_DELTA   = 1'b0;
   localparam logic CSR_DECODE_WINDOW = 1'b1;

   // circular slot arithmetic, valid for any table depth
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W+1)'(DEPTH))
         sum = sum - (IDX_W+1)'(DEPTH);
      return sum[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pts_frame_cache_lookup_core.sv =====
`default_nettype none
// frame timestamp cache with exact and covering lookup
//
// request channel: req_op, req_timestamp and req_duration transfer at a rising
// edge with start high and busy low. busy stays high until the result has been
// shown. each request gives exactly one result: rsp_valid is high for one
// cycle with rsp_found, rsp_entry_index and rsp_advice; the receiver cannot
// stall, so the result is taken in that cycle.
// steps, from the accepting edge to the strobe cycle:
//   add, table not full        append, then result
//   add, table full            range rebuild over the surviving 3/4 of the
//                              table, one entry a cycle, then append, result
//   find outside stored range  straight to the result
//   find inside stored range   scan of up to entry_count entries, ends early on a hit
// the rate is set by the single table read port feeding one compare unit,
// one stored entry per cycle; a new request is taken the cycle after the strobe.
// csr port: csr_write_en writes csr_write_data into register csr_index at once;
// write only while busy is low.
// reset (synchronous, active high) empties the table, drops the range and the
// last-added stamp, and sets frame_delta and decode_window to 1. stored
// entries are not cleared; only written entries are ever read.
module pts_frame_cache_lookup_core
   import pfcl_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire  [1:0]                req_op,
   input  wire  signed [63:0]        req_timestamp,
   input  wire  [31:0]               req_duration,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [ENTRY_W-1:0]        rsp_entry_index,
   output logic [1:0]                rsp_advice,
   input  wire                       csr_write_en,
   input  wire                       csr_index,
   input  wire  [31:0]               csr_write_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_APPEND = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   // table storage, one write and one registered read port
   logic [63:0] stamp_mem [DEPTH];
   logic [31:0] dur_mem [DEPTH];

   logic [1:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic signed [63:0] t_ff, t_in;
   logic [31:0]        dur_ff, dur_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [63:0] low_ff, low_in;
   logic signed [63:0] high_ff, high_in;
   logic               rv_ff, rv_in;
   logic signed [63:0] latest_ff, latest_in;
   logic               lv_ff, lv_in;
   logic [31:0]        delta_ff;
   logic [15:0]        thresh_ff;
   logic [47:0]        limit_ff, limit_in;
   logic [63:0]        ahead_ff, ahead_in;
   logic               gt_ff, gt_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic signed [63:0] rd_stamp_ff;
   logic [31:0]        rd_dur_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   wr_addr;

   // shared compare unit: range widen or lookup match on one stamp
   logic signed [63:0] cmp_src;
   logic               widen_en;
   logic [63:0]        span_off;
   logic               hit;
   logic               in_range;
   logic               issue;

   assign cmp_src  = (state_ff == ST_APPEND) ? t_ff : rd_stamp_ff;
   assign span_off = 64'(t_ff - rd_stamp_ff);
   always_comb begin
      case (op_ff)
         OP_EXACT: hit = (rd_stamp_ff == t_ff);
         OP_COVER: hit = (rd_stamp_ff <= t_ff) && (span_off[63:32] == 32'd0)
                         && (span_off[31:0] < rd_dur_ff);
         default:  hit = 1'b0;
      endcase
   end

   assign in_range = rv_ff && (req_timestamp >= low_ff) && (req_timestamp <= high_ff);
   assign issue    = (issue_ff < count_ff);
   assign rd_addr  = slot_add(oldest_ff, issue_ff[IDX_W-1:0]);
   assign wr_addr  = slot_add(oldest_ff, count_ff[IDX_W-1:0]);
   assign mem_we   = (state_ff == ST_APPEND);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      t_in        = t_ff;
      dur_in      = dur_ff;
      oldest_in   = oldest_ff;
      count_in    = count_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      rv_in       = rv_ff;
      latest_in   = latest_ff;
      lv_in       = lv_ff;
      limit_in    = limit_ff;
      ahead_in    = ahead_ff;
      gt_in       = gt_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      found_in    = found_ff;
      idx_in      = idx_ff;
      widen_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               t_in     = req_timestamp;
               dur_in   = req_duration;
               found_in = 1'b0;
               idx_in   = '0;
               issue_in = '0;
               // advice inputs, settled before the scan starts
               limit_in = {16'd0, delta_ff} * {32'd0, thresh_ff};
               ahead_in = 64'(req_timestamp - latest_ff);
               gt_in    = (req_timestamp > latest_ff);
               case (req_op)
                  OP_ADD: begin
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        // drop the oldest quarter, then rebuild the range
                        oldest_in = slot_add(oldest_ff, IDX_W'(EVICT));
                        count_in  = CNT_W'(DEPTH - EVICT);
                        rv_in     = 1'b0;
                        low_in    = '0;
                        high_in   = '0;
                        state_in  = ST_SCAN;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  OP_EXACT, OP_COVER: begin
                     state_in = in_range ? ST_SCAN : ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in    = issue_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
            end
            if (pend_ff && (op_ff == OP_ADD))
               widen_en = 1'b1;
            if (pend_ff && hit) begin
               found_in = 1'b1;
               idx_in   = pend_idx_ff;
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end else if (!issue && !pend_ff) begin
               state_in = (op_ff == OP_ADD) ? ST_APPEND : ST_DONE;
            end
         end
         ST_APPEND: begin
            widen_en  = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            latest_in = t_ff;
            lv_in     = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (widen_en) begin
         if (!rv_ff || (cmp_src < low_ff))
            low_in = cmp_src;
         if (!rv_ff || (cmp_src > high_ff))
            high_in = cmp_src;
         rv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
         low_ff    <= '0;
         high_ff   <= '0;
         rv_ff     <= 1'b0;
         latest_ff <= '0;
         lv_ff     <= 1'b0;
         pend_ff   <= 1'b0;
         delta_ff  <= 32'd1;
         thresh_ff <= 16'd1;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         rv_ff     <= rv_in;
         latest_ff <= latest_in;
         lv_ff     <= lv_in;
         pend_ff   <= pend_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_DELTA:   delta_ff  <= csr_write_data;
               CSR_DECODE_WINDOW: thresh_ff <= csr_write_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      t_ff        <= t_in;
      dur_ff      <= dur_in;
      limit_ff    <= limit_in;
      ahead_ff    <= ahead_in;
      gt_ff       <= gt_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[wr_addr] <= t_ff;
         dur_mem[wr_addr]   <= dur_ff;
      end
      rd_stamp_ff <= stamp_mem[rd_addr];
      rd_dur_ff   <= dur_mem[rd_addr];
   end

   // result transfer
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_found       = found_ff;
   assign rsp_entry_index = ENTRY_W'(idx_ff);
   always_comb begin
      if (found_ff) begin
         rsp_advice = ADV_NONE;
      end else begin
         case (op_ff)
            OP_EXACT: rsp_advice = (lv_ff && gt_ff && (ahead_ff < {16'd0, limit_ff}))
                                   ? ADV_CONT : ADV_SEEK;
            OP_COVER: rsp_advice = ADV_SEEK;
            default:  rsp_advice = ADV_NONE;
         endcase
      end
   end

   // checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   a_found_advice: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_advice == ADV_NONE))
      else $error("advice given on a hit");

   a_range_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (rv_ff == (count_ff != '0)))
      else $error("range valid out of step with entry count");

endmodule
`default_nettype wire
